@@ design/bbcd_pkg.sv @@
package bbcd_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int PX_W   = 10;
	localparam int SUM_W  = $clog2(MAX_DIM) + PX_W;
	localparam int DIV_W  = DIM_W + 2;
	localparam int THR_W  = DIV_W + 9;

	localparam int COMP_W  = 8;
	localparam int FNUM_W  = 32;
	localparam int STEP_W  = 16;
	localparam int GEOM_W  = 12;
	localparam int FIELD_W = 12;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int DCNT_W  = $clog2(FNUM_W);

	localparam logic [1:0] WARM_FRAMES = 2'd3;

	localparam logic [COMP_W-1:0] RST_BLACK_LIMIT = 8'd24;
	localparam logic [GEOM_W-1:0] RST_WIDTH       = 12'd720;
	localparam logic [GEOM_W-1:0] RST_HEIGHT      = 12'd576;

	localparam logic [CFG_IDX_W-1:0] REG_BLACK_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_START  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_END    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

	localparam logic SEL_START = 1'b0;
	localparam logic SEL_ID    = 1'b1;

	typedef struct packed {
		logic accept;
		logic warm_inc;
		logic div_start;
		logic div_sel;
		logic latch_phase;
		logic set_active;
		logic commit;
	} bbcd_cmd_t;

	typedef struct packed {
		logic first_px;
		logic warm_done;
		logic div_done;
		logic result_hit;
		logic out_busy;
	} bbcd_status_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [GEOM_W-1:0] v, input int maxv);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (32'(v) > maxv)
			r = DIM_W'(maxv);
		else
			r = DIM_W'(v);
		return r;
	endfunction

endpackage

@@ design/bbcd_ram.sv @@
module bbcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/bbcd_rem_div.sv @@
module bbcd_rem_div
	import bbcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FNUM_W-1:0] dividend,
	input  logic [STEP_W-1:0] divisor,
	output logic              done,
	output logic [STEP_W-1:0] rem
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [FNUM_W-1:0] dvd_q;
	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] dsr_q;
	logic [STEP_W:0]   trial;

	assign trial = {rem_q, dvd_q[FNUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(FNUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[FNUM_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q})
				rem_q <= STEP_W'(trial - {1'b0, dsr_q});
			else
				rem_q <= trial[STEP_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ design/bbcd_datapath.sv @@
module bbcd_datapath
	import bbcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbcd_cmd_t            cmd,
	output bbcd_status_t         st,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [COMP_W-1:0]    comp_a,
	input  logic [COMP_W-1:0]    comp_b,
	input  logic [COMP_W-1:0]    comp_c,
	input  logic [FNUM_W-1:0]    frame_number,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [FIELD_W-1:0]   crop_top,
	output logic [FIELD_W-1:0]   crop_left,
	output logic [FIELD_W-1:0]   crop_bottom,
	output logic [FIELD_W-1:0]   crop_right,
	output logic [FIELD_W-1:0]   top_bound,
	output logic [FIELD_W-1:0]   bottom_bound,
	output logic [FIELD_W-1:0]   left_bound,
	output logic [FIELD_W-1:0]   right_bound
);

	// configuration
	logic [COMP_W-1:0] black_limit_q;
	logic [FNUM_W-1:0] range_start_q;
	logic [FNUM_W-1:0] range_end_q;
	logic [STEP_W-1:0] frame_step_q;
	logic              pixel_format_q;
	logic [GEOM_W-1:0] frame_width_q;
	logic [GEOM_W-1:0] frame_height_q;

	// frame state
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SUM_W-1:0]  row_sum_q;
	logic [DIM_W-1:0]  top_q, left_q, bottom_q, right_q;
	logic [1:0]        warm_q;
	logic              active_q;
	logic              phase_q;
	logic [PX_W-1:0]   px_q;
	logic [FNUM_W-1:0] id_q;
	logic              out_valid_q;

	// thresholds
	logic [DIV_W-1:0]  row_div_q, col_div_q;
	logic [THR_W-1:0]  row_thr_q, col_thr_q;

	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [DIV_W-1:0]  w_ext, h_ext;
	logic [STEP_W-1:0] step_eff;
	logic [FNUM_W-1:0] div_dvd;
	logic              div_done;
	logic [STEP_W-1:0] div_rem;
	logic [SUM_W-1:0]  col_rd;
	logic [SUM_W-1:0]  col_new, row_new;
	logic              last_col, last_row, hit;
	logic              row_bright, col_bright;
	logic [DIM_W-1:0]  x_ext, y_ext;
	logic [DIM_W-1:0]  top_n, left_n, bottom_n, right_n;
	logic [DIM_W:0]    bot_even, right_even;
	logic [DIM_W:0]    top_even, left_even;
	logic [DIM_W-1:0]  bot_margin, right_margin;
	logic              in_range;

	assign w_eff    = eff_dim(frame_width_q, MAX_WIDTH);
	assign h_eff    = eff_dim(frame_height_q, MAX_HEIGHT);
	assign w_ext    = DIV_W'(w_eff);
	assign h_ext    = DIV_W'(h_eff);
	assign step_eff = (frame_step_q == '0) ? STEP_W'(1) : frame_step_q;
	assign div_dvd  = (cmd.div_sel == SEL_ID) ? id_q : range_start_q;

	bbcd_rem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (step_eff),
		.done     (div_done),
		.rem      (div_rem)
	);

	bbcd_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_col_sums (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (col_q),
		.wdata (col_new),
		.raddr (col_q),
		.rdata (col_rd)
	);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_limit_q  <= RST_BLACK_LIMIT;
			range_start_q  <= '0;
			range_end_q    <= '1;
			frame_step_q   <= STEP_W'(1);
			pixel_format_q <= 1'b0;
			frame_width_q  <= RST_WIDTH;
			frame_height_q <= RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLACK_LIMIT:  black_limit_q  <= cfg_data[COMP_W-1:0];
				REG_RANGE_START:  range_start_q  <= cfg_data[FNUM_W-1:0];
				REG_RANGE_END:    range_end_q    <= cfg_data[FNUM_W-1:0];
				REG_FRAME_STEP:   frame_step_q   <= cfg_data[STEP_W-1:0];
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_data[0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[GEOM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[GEOM_W-1:0];
				default: ;
			endcase
		end
	end

	// bright test: floor(sum / d) > limit  <=>  sum >= (limit + 1) * d
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_div_q <= '0;
			col_div_q <= '0;
			row_thr_q <= '0;
			col_thr_q <= '0;
		end else begin
			row_div_q <= pixel_format_q ? (w_ext + (w_ext << 1)) : w_ext;
			col_div_q <= pixel_format_q ? (h_ext + (h_ext << 1)) : h_ext;
			row_thr_q <= THR_W'({1'b0, black_limit_q} + 9'd1) * THR_W'(row_div_q);
			col_thr_q <= THR_W'({1'b0, black_limit_q} + 9'd1) * THR_W'(col_div_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= pixel_format_q ?
				(PX_W'(comp_a) + PX_W'(comp_b) + PX_W'(comp_c)) : PX_W'(comp_a);
			id_q <= frame_number;
		end
	end

	assign x_ext    = DIM_W'(col_q);
	assign y_ext    = DIM_W'(row_q);
	assign col_new  = (row_q == '0) ? SUM_W'(px_q) : col_rd + SUM_W'(px_q);
	assign row_new  = (col_q == '0) ? SUM_W'(px_q) : row_sum_q + SUM_W'(px_q);
	assign last_col = (x_ext + DIM_W'(1)) >= w_eff;
	assign last_row = (y_ext + DIM_W'(1)) >= h_eff;
	assign hit      = active_q && last_col && last_row;
	assign row_bright = active_q && last_col && (THR_W'(row_new) >= row_thr_q);
	assign col_bright = active_q && last_row && (THR_W'(col_new) >= col_thr_q);
	assign in_range = (range_start_q <= id_q) && (id_q <= range_end_q);

	always_comb begin
		top_n    = top_q;
		bottom_n = bottom_q;
		left_n   = left_q;
		right_n  = right_q;
		if (row_bright) begin
			if (y_ext < top_q)
				top_n = y_ext;
			if (y_ext > bottom_q)
				bottom_n = y_ext;
		end
		if (col_bright) begin
			if (x_ext < left_q)
				left_n = x_ext;
			if (x_ext > right_q)
				right_n = x_ext;
		end
	end

	// even rounding of the bounds
	assign top_even   = ({1'b0, top_n} + (DIM_W+1)'(1)) & ~(DIM_W+1)'(1);
	assign left_even  = ({1'b0, left_n} + (DIM_W+1)'(1)) & ~(DIM_W+1)'(1);
	assign bot_even   = ({1'b0, bottom_n} + (DIM_W+1)'(1)) & ~(DIM_W+1)'(1);
	assign right_even = ({1'b0, right_n} + (DIM_W+1)'(1)) & ~(DIM_W+1)'(1);
	assign bot_margin   = (bot_even > {1'b0, h_eff}) ? '0 :
		DIM_W'({1'b0, h_eff} - bot_even);
	assign right_margin = (right_even > {1'b0, w_eff}) ? '0 :
		DIM_W'({1'b0, w_eff} - right_even);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
			top_q     <= eff_dim(RST_HEIGHT, MAX_HEIGHT);
			left_q    <= eff_dim(RST_WIDTH, MAX_WIDTH);
			bottom_q  <= '0;
			right_q   <= '0;
			warm_q    <= '0;
			active_q  <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_FRAME_WIDTH)
				left_q <= eff_dim(cfg_data[GEOM_W-1:0], MAX_WIDTH);
			if (cfg_we && cfg_index == REG_FRAME_HEIGHT)
				top_q <= eff_dim(cfg_data[GEOM_W-1:0], MAX_HEIGHT);
			if (cmd.warm_inc) begin
				warm_q   <= warm_q + 2'd1;
				active_q <= 1'b0;
			end
			if (cmd.latch_phase)
				phase_q <= (div_rem != '0);
			if (cmd.set_active)
				active_q <= in_range && (div_rem == STEP_W'(phase_q));
			if (cmd.commit) begin
				row_sum_q <= row_new;
				top_q     <= top_n;
				bottom_q  <= bottom_n;
				left_q    <= left_n;
				right_q   <= right_n;
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q    <= '0;
						active_q <= 1'b0;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit && hit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && hit) begin
			crop_top     <= FIELD_W'(top_even);
			crop_left    <= FIELD_W'(left_even);
			crop_bottom  <= FIELD_W'(bot_margin);
			crop_right   <= FIELD_W'(right_margin);
			top_bound    <= FIELD_W'(top_n);
			bottom_bound <= FIELD_W'(bottom_n);
			left_bound   <= FIELD_W'(left_n);
			right_bound  <= FIELD_W'(right_n);
		end
	end

	assign out_valid = out_valid_q;

	assign st.first_px   = (col_q == '0) && (row_q == '0);
	assign st.warm_done  = (warm_q == WARM_FRAMES);
	assign st.div_done   = div_done;
	assign st.result_hit = hit;
	assign st.out_busy   = out_valid_q && out_stall;

endmodule

@@ design/bbcd_ctrl.sv @@
module bbcd_ctrl
	import bbcd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  bbcd_status_t st,
	output bbcd_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_PHASE = 3'd2;
	localparam logic [2:0] S_FRAME = 3'd3;
	localparam logic [2:0] S_UPD   = 3'd4;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_READ;
				end
			end
			S_READ: begin
				if (st.first_px && st.warm_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = SEL_START;
					state_d       = S_PHASE;
				end else begin
					cmd.warm_inc = st.first_px;
					state_d      = S_UPD;
				end
			end
			S_PHASE: begin
				if (st.div_done) begin
					cmd.latch_phase = 1'b1;
					cmd.div_start   = 1'b1;
					cmd.div_sel     = SEL_ID;
					state_d         = S_FRAME;
				end
			end
			S_FRAME: begin
				if (st.div_done) begin
					cmd.set_active = 1'b1;
					state_d        = S_UPD;
				end
			end
			S_UPD: begin
				if (!(st.result_hit && st.out_busy)) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

@@ design/black_border_crop_detector.sv @@
// channel  direction  handshake            payload
// pixel    in         in_valid / in_stall   comp_a comp_b comp_c frame_number
// result   out        out_valid / out_stall crop_* and *_bound, one per analysed frame
// config   in         cfg_we                cfg_index cfg_data
//
// a pixel goes through accept, column sum read from the ram, then update
// the first pixel of a frame after warm-up adds two passes of the bit-serial
// remainder unit over the 32-bit dividend (phase of range_start, then frame number)
// the last pixel of an analysed frame waits in update while an earlier result beat is stalled
// reset is asynchronous; column sums are not cleared, row 0 of each frame writes them
module black_border_crop_detector
	import bbcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COMP_W-1:0]    comp_a,
	input  logic [COMP_W-1:0]    comp_b,
	input  logic [COMP_W-1:0]    comp_c,
	input  logic [FNUM_W-1:0]    frame_number,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FIELD_W-1:0]   crop_top,
	output logic [FIELD_W-1:0]   crop_left,
	output logic [FIELD_W-1:0]   crop_bottom,
	output logic [FIELD_W-1:0]   crop_right,
	output logic [FIELD_W-1:0]   top_bound,
	output logic [FIELD_W-1:0]   bottom_bound,
	output logic [FIELD_W-1:0]   left_bound,
	output logic [FIELD_W-1:0]   right_bound
);

	bbcd_cmd_t    cmd;
	bbcd_status_t st;

	bbcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	bbcd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.comp_a       (comp_a),
		.comp_b       (comp_b),
		.comp_c       (comp_c),
		.frame_number (frame_number),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.crop_top     (crop_top),
		.crop_left    (crop_left),
		.crop_bottom  (crop_bottom),
		.crop_right   (crop_right),
		.top_bound    (top_bound),
		.bottom_bound (bottom_bound),
		.left_bound   (left_bound),
		.right_bound  (right_bound)
	);

endmodule
